[rtl/core/ralu_pkg.sv]
// Shared types and constants for the register ALU with flags.
package ralu_pkg;

  // Register file geometry
  localparam int NUM_REGS = 8;
  localparam int REG_W    = 16;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int SEL_W    = 3;
  localparam int CMD_W    = 4;
  localparam int FLG_W    = 4;

  // Flag word bit positions
  localparam int FLG_Z = 0;
  localparam int FLG_O = 1;
  localparam int FLG_C = 2;
  localparam int FLG_N = 3;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 4'd0,
    CMD_XCHG = 4'd1,
    CMD_ADD  = 4'd2,
    CMD_SUB  = 4'd3,
    CMD_MUL  = 4'd4,
    CMD_DIV  = 4'd5,
    CMD_NOT  = 4'd6,
    CMD_AND  = 4'd7,
    CMD_OR   = 4'd8,
    CMD_XOR  = 4'd9,
    CMD_TEST = 4'd10,
    CMD_SHL  = 4'd11,
    CMD_SHR  = 4'd12,
    CMD_CMP  = 4'd13
  } cmd_t;

  // Combinational ALU outcome
  typedef struct packed {
    logic [REG_W-1:0] value;
    logic             we;
    logic [FLG_W-1:0] flags;
  } alu_res_t;

endpackage

[rtl/core/ralu_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module ralu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ralu_pkg::REG_W-1:0]   dividend,
  input  logic [ralu_pkg::REG_W-1:0]   divisor,
  output logic                         done,
  output logic [ralu_pkg::REG_W-1:0]   quotient
);

  localparam int W     = ralu_pkg::REG_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;

  logic [W-1:0]     dvd_mag;
  logic [W-1:0]     dvs_mag;
  logic [W-1:0]     trial;
  logic [W:0]       diff;

  // Magnitudes; the most negative value maps to its unsigned magnitude
  assign dvd_mag = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign dvs_mag = divisor[W-1]  ? (~divisor + W'(1))  : divisor;

  // Restoring step: bring down the next dividend bit and try a subtract
  assign trial = {rem_r[W-2:0], quo_r[W-1]};
  assign diff  = {1'b0, trial} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dvd_mag;
      dvs_r <= dvs_mag;
      rem_r <= '0;
      neg_r <= dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
      end else begin
        rem_r <= trial;
      end
      quo_r <= {quo_r[W-2:0], ~diff[W]};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + W'(1)) : quo_r;

endmodule

[rtl/core/ralu_alu.sv]
// Combinational ALU for all commands but divide: result, write enable, flags.
module ralu_alu (
  input  logic [ralu_pkg::CMD_W-1:0] cmd,
  input  logic [ralu_pkg::REG_W-1:0] op_a,
  input  logic [ralu_pkg::REG_W-1:0] op_b,
  input  logic [ralu_pkg::REG_W-1:0] imm,
  input  logic [ralu_pkg::FLG_W-1:0] flags_in,
  output ralu_pkg::alu_res_t         res
);

  localparam int W = ralu_pkg::REG_W;

  logic [W-1:0] sub_r;
  logic [W-1:0] and_r;
  logic         sh_big;
  logic [W:0]   shl_ext;
  logic [W:0]   shr_ext;
  logic [W-1:0] shl_val;
  logic         shl_c;
  logic [W-1:0] shr_val;
  logic         shr_c;
  logic [W-1:0] fill;

  assign sub_r  = op_a - op_b;
  assign and_r  = op_a & op_b;
  assign sh_big = (op_b >= W'(W));
  assign fill   = {W{op_a[W-1]}};

  // Shifts: the extra bit catches the last bit shifted out
  assign shl_ext = {1'b0, op_a} << op_b[$clog2(W)-1:0];
  assign shr_ext = $unsigned($signed({op_a, 1'b0}) >>> op_b[$clog2(W)-1:0]);
  assign shl_val = sh_big ? '0 : shl_ext[W-1:0];
  assign shl_c   = sh_big ? ((op_b == W'(W)) && op_a[0]) : shl_ext[W];
  assign shr_val = sh_big ? fill : shr_ext[W:1];
  assign shr_c   = sh_big ? op_a[W-1] : shr_ext[0];

  always_comb begin
    res.value = op_a;
    res.we    = 1'b0;
    res.flags = flags_in;
    case (cmd)
      ralu_pkg::CMD_LOAD: begin
        res.value = imm;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_XCHG: begin
        res.value = op_b;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_ADD: begin
        res.value = op_a + op_b;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_SUB: begin
        res.value = sub_r;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_MUL: begin
        res.value = op_a * op_b;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_NOT: begin
        res.value = ~op_a;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_AND: begin
        res.value = and_r;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_OR: begin
        res.value = op_a | op_b;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_XOR: begin
        res.value = op_a ^ op_b;
        res.we    = 1'b1;
      end
      ralu_pkg::CMD_TEST: begin
        res.flags[ralu_pkg::FLG_Z] = (and_r == '0);
        res.flags[ralu_pkg::FLG_N] = and_r[W-1];
      end
      ralu_pkg::CMD_SHL: begin
        res.value                  = shl_val;
        res.we                     = 1'b1;
        res.flags[ralu_pkg::FLG_Z] = (shl_val == '0);
        res.flags[ralu_pkg::FLG_N] = shl_val[W-1];
        res.flags[ralu_pkg::FLG_C] = shl_c;
      end
      ralu_pkg::CMD_SHR: begin
        res.value                  = shr_val;
        res.we                     = 1'b1;
        res.flags[ralu_pkg::FLG_Z] = (shr_val == '0);
        res.flags[ralu_pkg::FLG_N] = shr_val[W-1];
        res.flags[ralu_pkg::FLG_C] = shr_c;
      end
      ralu_pkg::CMD_CMP: begin
        res.flags[ralu_pkg::FLG_Z] = (sub_r == '0);
        res.flags[ralu_pkg::FLG_N] = sub_r[W-1];
        res.flags[ralu_pkg::FLG_C] = ($signed(op_a) < $signed(op_b));
        res.flags[ralu_pkg::FLG_O] = (op_a[W-1] ^ op_b[W-1]) & (op_a[W-1] ^ sub_r[W-1]);
      end
      default: begin
        // divide is handled by the divider; unused codes are no-ops
        res.we = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/register_alu_with_flags_unit.sv]
// Top level: register file, sequencer, shared ALU and iterative divider.
//
// Input channel (in_valid/in_ready) takes one instruction word: command,
// destination and source register indexes and a 16-bit immediate. The result
// channel (out_valid/out_ready) returns one word per instruction: destination
// and source register contents after the instruction, the flag word and the
// divide-by-zero indication.
// Sequence: an instruction is read from the register file, executed, written
// back and read back (states RD, EX, WB, RB, OUT); exchange adds a second
// write-back step, as it writes two registers through the single write port.
// A divide by a nonzero value adds a wait for the 16-step divider between
// execute and write-back; divides set the sustained rate.
// The block takes one instruction at a time; in_ready is low while it works.
// A finished word sits in the output register; the next instruction may be
// accepted and executed meanwhile, and its result waits until out_ready.
// Reset (rst_n low, synchronous) clears every register to zero at once
// through per-entry valid bits, clears the flags and drops out_valid.
module register_alu_with_flags_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ralu_pkg::CMD_W-1:0]         in_cmd,
  input  logic [ralu_pkg::SEL_W-1:0]         in_dst_reg,
  input  logic [ralu_pkg::SEL_W-1:0]         in_src_reg,
  input  logic signed [ralu_pkg::REG_W-1:0]  in_immediate,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ralu_pkg::REG_W-1:0]  out_dst_value,
  output logic signed [ralu_pkg::REG_W-1:0]  out_src_value,
  output logic [ralu_pkg::FLG_W-1:0]         out_flags,
  output logic                               out_div_zero
);

  localparam int W = ralu_pkg::REG_W;
  localparam int N = ralu_pkg::NUM_REGS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_DIV,
    ST_WB,
    ST_WB2,
    ST_RB,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Latched instruction word
  logic [ralu_pkg::CMD_W-1:0] cmd_r;
  logic [ralu_pkg::SEL_W-1:0] dst_r;
  logic [ralu_pkg::SEL_W-1:0] src_r;
  logic [W-1:0]               imm_r;

  // Register file storage and read ports
  logic [W-1:0]               mem [N];
  logic [N-1:0]               valid_r;
  logic [W-1:0]               rd_a_r;
  logic [W-1:0]               rd_b_r;
  logic                       a_ok_r;
  logic                       b_ok_r;

  // Execution results
  logic [W-1:0]               res_r;
  logic                       res_we_r;
  logic [W-1:0]               swap_r;
  logic [ralu_pkg::FLG_W-1:0] flag_r;
  logic                       dz_r;

  logic                       out_valid_r;
  logic [W-1:0]               out_dst_r;
  logic [W-1:0]               out_src_r;
  logic [ralu_pkg::FLG_W-1:0] out_flags_r;
  logic                       out_dz_r;

  logic [ralu_pkg::IDX_W-1:0] dst_idx;
  logic [ralu_pkg::IDX_W-1:0] src_idx;
  logic                       dst_in;
  logic                       src_in;
  logic [W-1:0]               op_a;
  logic [W-1:0]               op_b;
  logic                       is_div;
  logic                       div_start;
  logic                       div_done;
  logic [W-1:0]               div_q;
  ralu_pkg::alu_res_t         alu_res;

  logic                       wr_en;
  logic [ralu_pkg::IDX_W-1:0] wr_idx;
  logic [W-1:0]               wr_data;

  assign dst_idx = ralu_pkg::IDX_W'(dst_r);
  assign src_idx = ralu_pkg::IDX_W'(src_r);
  assign dst_in  = (32'(dst_r) < N);
  assign src_in  = (32'(src_r) < N);

  // Out-of-range or never-written registers read as zero
  assign op_a = a_ok_r ? rd_a_r : '0;
  assign op_b = b_ok_r ? rd_b_r : '0;

  assign is_div    = (cmd_r == ralu_pkg::CMD_DIV);
  assign div_start = (state_r == ST_EX) && is_div && (op_b != '0);

  ralu_alu u_alu (
    .cmd      (cmd_r),
    .op_a     (op_a),
    .op_b     (op_b),
    .imm      (imm_r),
    .flags_in (flag_r),
    .res      (alu_res)
  );

  ralu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Write port: destination in write-back, source on the exchange's second write
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = dst_idx;
    wr_data = res_r;
    if (state_r == ST_WB) begin
      wr_en = res_we_r && dst_in;
    end else if (state_r == ST_WB2) begin
      wr_en   = src_in;
      wr_idx  = src_idx;
      wr_data = swap_r;
    end
  end

  // Register file array: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_a_r <= mem[dst_idx];
    rd_b_r <= mem[src_idx];
  end

  // Entry valid bits and read qualifiers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      a_ok_r  <= 1'b0;
      b_ok_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      a_ok_r <= dst_in && valid_r[dst_idx];
      b_ok_r <= src_in && valid_r[src_idx];
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_EX;
      ST_EX:   state_nxt = div_start ? ST_DIV : ST_WB;
      ST_DIV:  if (div_done) state_nxt = ST_WB;
      ST_WB:   state_nxt = (cmd_r == ralu_pkg::CMD_XCHG) ? ST_WB2 : ST_RB;
      ST_WB2:  state_nxt = ST_RB;
      ST_RB:   state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, instruction latch, execution results and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flag_r      <= '0;
      res_we_r    <= 1'b0;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Output word leaves when taken, unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_cmd;
            dst_r <= in_dst_reg;
            src_r <= in_src_reg;
            imm_r <= in_immediate;
          end
        end
        ST_EX: begin
          res_r    <= alu_res.value;
          res_we_r <= alu_res.we;
          flag_r   <= alu_res.flags;
          swap_r   <= op_a;
          dz_r     <= is_div && (op_b == '0);
        end
        ST_DIV: begin
          if (div_done) begin
            res_r    <= div_q;
            res_we_r <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_dst_r   <= op_a;
            out_src_r   <= op_b;
            out_flags_r <= flag_r;
            out_dz_r    <= dz_r;
          end
        end
        default: begin
          res_we_r <= res_we_r;
        end
      endcase
    end
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_dst_value = out_dst_r;
  assign out_src_value = out_src_r;
  assign out_flags     = out_flags_r;
  assign out_div_zero  = out_dz_r;

  // A divide is never started on a zero divisor
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> (op_b != '0))
    else $error("divider started with zero divisor");

  // Divider completion is only seen while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n) div_done |-> (state_r == ST_DIV))
    else $error("divider done outside divide wait");

  // An accepted word always moves the sequencer to the read step
  assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> (state_r == ST_RD))
    else $error("accepted word did not start execution");

  // Written registers never fall back to the reset value without reset
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((valid_r & $past(valid_r)) == $past(valid_r)))
    else $error("register valid bit cleared outside reset");

  // Divide-by-zero suppresses any destination write
  assert property (@(posedge clk) disable iff (!rst_n) ((state_r == ST_WB) && dz_r) |-> !wr_en)
    else $error("write-back after divide by zero");

endmodule
